### sv/i2cmwr_pkg.sv
// Shared types and codes for the I2C master write/read sequencer.
package i2cmwr_pkg;

	localparam int unsigned AddrWidth  = 7;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned CountWidth = 8;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RESTART = 3'd3,
		CMD_STOP    = 3'd4,
		CMD_ACK     = 3'd5,
		CMD_NACK    = 3'd6,
		CMD_RECV    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NOACK    = 2'd1,
		STATUS_OVERFLOW = 2'd2,
		STATUS_RSVD     = 2'd3
	} status_t;

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [AddrWidth-1:0]  slave_address;
		logic [CountWidth-1:0] write_count;
		logic [CountWidth-1:0] read_count;
		logic                  start_seen;
		logic                  tx_ready;
		logic                  acked;
		logic                  rx_overflow;
		logic [ByteWidth-1:0]  rx_byte;
		logic [ByteWidth-1:0]  tx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           command;
		logic [ByteWidth-1:0] out_byte;
		logic                 read_valid;
		logic [ByteWidth-1:0] read_byte;
		logic                 done_res;
		logic [1:0]           status;
		logic                 busy_res;
	} out_item_t;

endpackage

### sv/i2cmwr_in_if.sv
// Valid/ready channel that carries begin and bus engine event beats.
interface i2cmwr_in_if;
	logic                 valid;
	logic                 ready;
	i2cmwr_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/i2cmwr_out_if.sv
// Valid/ready channel that carries command result beats.
interface i2cmwr_out_if;
	logic                  valid;
	logic                  ready;
	i2cmwr_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/i2c_master_write_read_sequencer_core.sv
// Top level of the I2C master write/read sequencer: input register, state machine, result register.
//
// Each beat on req is either a begin (slave address, write count, read count) or a report of
// what the byte-level bus engine saw; every beat yields exactly one beat on rsp with the next
// bus command, any received byte, and done/status/busy flags. A beat is taken into an input
// register, run through the state machine, and its result lands in an output register, so a new
// beat is accepted every cycle while rsp is ready; a result is offered on rsp from the output
// register after its beat has left the input register. While a finished result waits to be taken,
// one more beat can sit in the input register; further beats stall until rsp takes the result.
// A begin beat while a transaction runs answers with no command and busy set.
module i2c_master_write_read_sequencer_core (
	input  logic         clk,
	input  logic         arst_n,
	i2cmwr_in_if.sink    req,
	i2cmwr_out_if.source rsp
);

	logic                  valid_s1;
	i2cmwr_pkg::in_item_t  item_s1;
	logic                  out_valid_q;
	i2cmwr_pkg::out_item_t out_q;
	i2cmwr_pkg::out_item_t result;
	logic                  advance;

	// The registered beat moves on once the result register is free or being drained.
	assign advance   = valid_s1 & (~out_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	i2cmwr_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

endmodule

### sv/i2cmwr_fsm.sv
// Transaction state machine: holds phase and counters, computes one result per step.
module i2cmwr_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  i2cmwr_pkg::in_item_t  item,
	output i2cmwr_pkg::out_item_t result
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_ADDR_WR   = 4'd2,
		PH_WRITING   = 4'd3,
		PH_RESTART   = 4'd4,
		PH_ADDR_RD   = 4'd5,
		PH_READING   = 4'd6,
		PH_SEND_ACK  = 4'd7,
		PH_SEND_NACK = 4'd8,
		PH_STOPPING  = 4'd9,
		PH_ERR_NOACK = 4'd10,
		PH_ERR_OVF   = 4'd11
	} phase_t;

	localparam logic [i2cmwr_pkg::CountWidth-1:0] CountOne =
		{{(i2cmwr_pkg::CountWidth-1){1'b0}}, 1'b1};

	phase_t                                  phase_q, phase_d;
	logic [i2cmwr_pkg::CountWidth-1:0]       writes_left_q, writes_left_d;
	logic [i2cmwr_pkg::CountWidth-1:0]       reads_left_q, reads_left_d;
	logic [i2cmwr_pkg::AddrWidth-1:0]        target_address_q, target_address_d;
	logic [i2cmwr_pkg::ByteWidth-1:0]        wr_addr, rd_addr;
	logic                                    bus_started;

	assign wr_addr     = {target_address_q, 1'b0};
	assign rd_addr     = {target_address_q, 1'b1};
	assign bus_started = item.start_seen & item.tx_ready;

	always_comb begin
		phase_d          = phase_q;
		writes_left_d    = writes_left_q;
		reads_left_d     = reads_left_q;
		target_address_d = target_address_q;
		result           = '0;
		result.command   = i2cmwr_pkg::CMD_NONE;
		result.status    = i2cmwr_pkg::STATUS_OK;

		if (item.kind == i2cmwr_pkg::KIND_BEGIN) begin
			// A begin beat is dropped while a transaction runs.
			if (phase_q == PH_IDLE) begin
				target_address_d = item.slave_address;
				writes_left_d    = item.write_count;
				reads_left_d     = item.read_count;
				phase_d          = PH_START;
				result.command   = i2cmwr_pkg::CMD_START;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_START: begin
					if (bus_started) begin
						if (writes_left_q != '0) begin
							result.command  = i2cmwr_pkg::CMD_SEND;
							result.out_byte = wr_addr;
							phase_d         = PH_ADDR_WR;
						end else if (reads_left_q != '0) begin
							result.command  = i2cmwr_pkg::CMD_SEND;
							result.out_byte = rd_addr;
							phase_d         = PH_ADDR_RD;
						end else begin
							result.command = i2cmwr_pkg::CMD_STOP;
							phase_d        = PH_STOPPING;
						end
					end
				end
				PH_ADDR_WR, PH_WRITING: begin
					if (!item.acked) begin
						result.command = i2cmwr_pkg::CMD_STOP;
						phase_d        = PH_ERR_NOACK;
					end else if (writes_left_q != '0) begin
						writes_left_d   = writes_left_q - CountOne;
						result.command  = i2cmwr_pkg::CMD_SEND;
						result.out_byte = item.tx_byte;
						phase_d         = PH_WRITING;
					end else if (reads_left_q != '0) begin
						result.command = i2cmwr_pkg::CMD_RESTART;
						phase_d        = PH_RESTART;
					end else begin
						result.command = i2cmwr_pkg::CMD_STOP;
						phase_d        = PH_STOPPING;
					end
				end
				PH_RESTART: begin
					if (bus_started) begin
						result.command  = i2cmwr_pkg::CMD_SEND;
						result.out_byte = rd_addr;
						phase_d         = PH_ADDR_RD;
					end
				end
				PH_ADDR_RD: begin
					if (!item.acked) begin
						result.command = i2cmwr_pkg::CMD_STOP;
						phase_d        = PH_ERR_NOACK;
					end else if (reads_left_q != '0) begin
						reads_left_d = reads_left_q - CountOne;
						if (!item.rx_overflow) begin
							result.command = i2cmwr_pkg::CMD_RECV;
							phase_d        = PH_READING;
						end else begin
							result.command = i2cmwr_pkg::CMD_STOP;
							phase_d        = PH_ERR_OVF;
						end
					end else begin
						result.command = i2cmwr_pkg::CMD_STOP;
						phase_d        = PH_STOPPING;
					end
				end
				PH_READING: begin
					result.read_valid = 1'b1;
					result.read_byte  = item.rx_byte;
					if (reads_left_q != '0) begin
						reads_left_d   = reads_left_q - CountOne;
						result.command = i2cmwr_pkg::CMD_ACK;
						phase_d        = PH_SEND_ACK;
					end else begin
						result.command = i2cmwr_pkg::CMD_NACK;
						phase_d        = PH_SEND_NACK;
					end
				end
				PH_SEND_ACK: begin
					if (!item.rx_overflow) begin
						result.command = i2cmwr_pkg::CMD_RECV;
						phase_d        = PH_READING;
					end else begin
						result.command = i2cmwr_pkg::CMD_STOP;
						phase_d        = PH_ERR_OVF;
					end
				end
				PH_SEND_NACK: begin
					result.command = i2cmwr_pkg::CMD_STOP;
					phase_d        = PH_STOPPING;
				end
				PH_STOPPING: begin
					result.done_res = 1'b1;
					result.status   = i2cmwr_pkg::STATUS_OK;
					phase_d         = PH_IDLE;
				end
				PH_ERR_NOACK: begin
					result.done_res = 1'b1;
					result.status   = i2cmwr_pkg::STATUS_NOACK;
					phase_d         = PH_IDLE;
				end
				PH_ERR_OVF: begin
					result.done_res = 1'b1;
					result.status   = i2cmwr_pkg::STATUS_OVERFLOW;
					phase_d         = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		result.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			writes_left_q    <= '0;
			reads_left_q     <= '0;
			target_address_q <= '0;
		end else if (step) begin
			phase_q          <= phase_d;
			writes_left_q    <= writes_left_d;
			reads_left_q     <= reads_left_d;
			target_address_q <= target_address_d;
		end
	end

endmodule
